// ===== design/htf_pkg.sv =====
// ----------------------------------------------------------------------------
// htf_pkg
// Shared types, constants and helper functions of the hex telemetry framer.
// ----------------------------------------------------------------------------
package htf_pkg;

  typedef enum logic [2:0] {
    KIND_RAW   = 3'd0,
    KIND_HEX   = 3'd1,
    KIND_PHASE = 3'd2,
    KIND_MAG   = 3'd3,
    KIND_EOL   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_item_t;

  // One classified item waiting for the character generator. For an end of
  // line the low byte of data carries the checksum taken before the reset.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] data;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CRC_POLY     = 8'h07;
  localparam logic [7:0] CRC_EOL_INIT = 8'hFF;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;

  // CRC-8 over one byte, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Uppercase ASCII hex digit of one nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CHAR_ZERO + {4'h0, nib};
    end else begin
      ch = CHAR_UPPER_A + {4'h0, nib} - 8'd10;
    end
    return ch;
  endfunction

endpackage

// ===== design/htf_front.sv =====
// ----------------------------------------------------------------------------
// htf_front
// Accepts telemetry items, updates the running checksum and pushes each
// accepted item of a used kind into the queue.
// ----------------------------------------------------------------------------
module htf_front import htf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  input  q_status_t q_stat,
  output logic      push,
  output q_entry_t  push_entry,
  output logic [7:0] crc
);

  logic [7:0] crc_next;
  logic       kind_ok;
  logic       accept;

  assign item_ready = !q_stat.full;
  assign accept     = item_valid && item_ready;
  assign push       = accept && kind_ok;

  always_comb begin
    crc_next        = crc;
    kind_ok         = 1'b1;
    push_entry.kind = kind_t'(item.kind);
    push_entry.data = item.value;
    case (item.kind)
      KIND_RAW: begin
      end
      KIND_HEX: begin
        crc_next = crc8_byte(crc, item.value[7:0]);
      end
      KIND_PHASE, KIND_MAG: begin
        crc_next = crc8_byte(crc8_byte(crc, item.value[15:8]), item.value[7:0]);
      end
      KIND_EOL: begin
        push_entry.data = {8'h00, crc};
        crc_next        = CRC_EOL_INIT;
      end
      default: begin
        // Unused kind codes are taken and dropped.
        kind_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= 8'h00;
    end else if (accept) begin
      crc <= crc_next;
    end
  end

endmodule

// ===== design/htf_queue.sv =====
// ----------------------------------------------------------------------------
// htf_queue
// Short first-in first-out queue between the front and the character
// generator.
// ----------------------------------------------------------------------------
module htf_queue import htf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  q_entry_t            push_entry,
  input  logic                pop,
  output q_entry_t            head,
  output q_status_t           q_stat,
  output logic [QUEUE_CW-1:0] count
);

  q_entry_t            slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;

  function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
    logic [QUEUE_AW-1:0] n;
    if (p == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  assign head         = slots[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == QUEUE_CW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/htf_back.sv =====
// ----------------------------------------------------------------------------
// htf_back
// Character generator: walks the queue head one character per cycle, while
// the receiver takes them, into a registered output stage.
// ----------------------------------------------------------------------------
module htf_back import htf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_entry_t  head,
  input  q_status_t q_stat,
  output logic      pop,
  output logic      char_valid,
  input  logic      char_ready,
  output out_item_t char_item
);

  logic [1:0] idx;
  logic [1:0] last_idx;
  logic [1:0] nib_top;
  logic [1:0] nib_pos;
  logic [3:0] nib;
  logic [7:0] ch;
  logic       advance;
  logic       emit;
  logic       at_last;

  always_comb begin
    case (head.kind)
      KIND_RAW:   last_idx = 2'd0;
      KIND_HEX:   last_idx = 2'd1;
      KIND_PHASE: last_idx = 2'd2;
      default:    last_idx = 2'd3;
    endcase
  end

  // Digits go out most significant nibble first; the checksum digits of an
  // end of line come from the low byte.
  assign nib_top = (head.kind == KIND_EOL) ? 2'd1 : last_idx;
  assign nib_pos = nib_top - idx;
  assign nib     = head.data[{nib_pos, 2'b00} +: 4];

  always_comb begin
    ch = hex_digit(nib);
    case (head.kind)
      KIND_RAW: begin
        ch = head.data[7:0];
      end
      KIND_EOL: begin
        if (idx == 2'd2) begin
          ch = CHAR_CR;
        end else if (idx == 2'd3) begin
          ch = CHAR_LF;
        end
      end
      default: begin
      end
    endcase
  end

  assign advance = !char_valid || char_ready;
  assign emit    = advance && !q_stat.empty;
  assign at_last = (idx == last_idx);
  assign pop     = emit && at_last;

  always_ff @(posedge clk) begin
    if (emit) begin
      char_item.char_out <= ch;
      char_item.last     <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      idx        <= 2'd0;
    end else if (advance) begin
      char_valid <= emit;
      if (emit) begin
        idx <= at_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule

// ===== design/hex_telemetry_framer_crc8.sv =====
// ----------------------------------------------------------------------------
// hex_telemetry_framer_crc8
// Turns telemetry items into uppercase ASCII hex characters with a running
// CRC-8 (polynomial 0x07, MSB first) sent at each end of line.
// ----------------------------------------------------------------------------
// Usage: items enter on the item channel (item_valid, item_ready, item) as a
// kind and a 16-bit value. Characters leave on the char channel (char_valid,
// char_ready, char_item), one transaction per character, with last set on
// the final character of each item. A raw byte gives one character, a hex
// byte two, a phase value three, a magnitude four, and an end of line gives
// the two checksum digits followed by CR and LF. Unused kind codes are taken
// and produce nothing.
// Path: an item is written into the queue first; its characters then pass
// through the output register, which loads a new one only while the output
// side is free.
// Throughput: one character per cycle while the receiver is ready; an item
// has one to four characters, and the single output register sets the pace.
// A two-entry queue lets the front take items while the back is busy.
// Reset (rst, synchronous) empties the queue and the output stage and clears
// the checksum to zero. When the receiver stalls, the held character stays
// put, the back stops, the queue fills, and item_ready falls.
// ----------------------------------------------------------------------------
module hex_telemetry_framer_crc8 import htf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      char_valid,
  input  logic      char_ready,
  output out_item_t char_item
);

  logic                q_push;
  logic                q_pop;
  q_entry_t            q_in;
  q_entry_t            q_head;
  q_status_t           q_stat;
  logic [QUEUE_CW-1:0] q_count;
  logic [7:0]          crc;

  // Front: checksum update and classification.
  htf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_stat     (q_stat),
    .push       (q_push),
    .push_entry (q_in),
    .crc        (crc)
  );

  // Queue decoupling the two sides.
  htf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .q_stat     (q_stat),
    .count      (q_count)
  );

  // Back: one character per cycle, while the receiver is ready, into the output register.
  htf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item)
  );

`ifndef ASSERT_OFF
  // The front never writes into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && (q_count == QUEUE_CW'(QUEUE_DEPTH))))
    else $error("push into full queue");

  // The back never takes from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && (q_count == '0)))
    else $error("pop from empty queue");

  // An accepted end of line restarts the checksum at 0xFF.
  a_eol_crc: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && (item.kind == KIND_EOL)) |=> (crc == CRC_EOL_INIT))
    else $error("checksum not restarted after end of line");
`endif

endmodule
